@@ rtl/core/align_rotation_apply_defines.svh @@
// Assertion helpers for the align-and-rotate RTL.
// Each macro expands to one labeled concurrent assertion on clk, disabled in reset.
`ifndef ALIGN_ROTATION_APPLY_DEFINES_SVH
`define ALIGN_ROTATION_APPLY_DEFINES_SVH

// Same-cycle implication.
`define ARA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("align_rotation_apply: same-cycle check failed");

// Next-cycle implication.
`define ARA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("align_rotation_apply: next-cycle check failed");

`endif

@@ rtl/core/ara_pkg.sv @@
`timescale 1ns / 1ps

package ara_pkg;

  // Fixed widths of the length and square-root datapath.
  localparam int SQ_W       = 32;  // sum of three squared 16-bit components
  localparam int ROOT_W     = 31;  // floor(sqrt(s * 2^30))
  localparam int REM_W      = 32;  // partial remainder of the root
  localparam int SQ_STEPS   = 31;  // one root bit per stage
  localparam int PRE_STAGES = 3;   // input, squares, sum

  // Which of the six distinct entries of K^2 feeds each matrix position.
  // Entries 0..2 are the diagonal, 3..5 are (0,1), (0,2) and (1,2).
  localparam logic [2:0] K2_SEL [3][3] = '{
    '{3'd0, 3'd3, 3'd4},
    '{3'd3, 3'd1, 3'd5},
    '{3'd4, 3'd5, 3'd2}
  };

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vec3_t;

  typedef struct packed {
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] from_z;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic signed [15:0] to_z;
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               degenerate;
  } out_beat_t;

endpackage

@@ rtl/core/ara_div_pipe.sv @@
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage, rounding to
// nearest with ties away from zero. The sign is applied after the magnitude.
module ara_div_pipe #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16,
  parameter int QUO_W = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [NUM_W-1:0]        num,
  input  logic [DEN_W-1:0]        den,
  input  logic                    neg,
  output logic signed [QUO_W:0]   quo
);

  logic [NUM_W:0]   sum_c;
  logic [DEN_W-1:0] rem_q  [0:QUO_W];
  logic [QUO_W-1:0] low_q  [0:QUO_W];
  logic [DEN_W-1:0] den_q  [0:QUO_W];
  logic             neg_q  [0:QUO_W];
  logic [DEN_W-1:0] rem_next [1:QUO_W];
  logic             bit_next [1:QUO_W];

  assign sum_c = (NUM_W+1)'(num) + (NUM_W+1)'(den >> 1);

  always_comb begin
    logic [DEN_W:0] t;
    for (int k = 1; k <= QUO_W; k++) begin
      t = {rem_q[k-1], low_q[k-1][QUO_W-1]};
      bit_next[k] = (t >= {1'b0, den_q[k-1]});
      rem_next[k] = bit_next[k] ? DEN_W'(t - {1'b0, den_q[k-1]}) : DEN_W'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= DEN_W'(sum_c >> QUO_W);
      low_q[0] <= QUO_W'(sum_c);
      den_q[0] <= den;
      neg_q[0] <= neg;
      for (int k = 1; k <= QUO_W; k++) begin
        rem_q[k] <= rem_next[k];
        low_q[k] <= {low_q[k-1][QUO_W-2:0], bit_next[k]};
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
      quo <= neg_q[QUO_W] ? -$signed({1'b0, low_q[QUO_W]}) : $signed({1'b0, low_q[QUO_W]});
    end
  end

endmodule

@@ rtl/core/align_rotation_apply.sv @@
`timescale 1ns / 1ps
// Throughput: one beat per cycle while result_stall does not freeze the pipeline;
// the length roots and both divider pipelines resolve one bit per stage, which sets
// the depth but not the rate.
// Reset clears every valid bit of the pipeline; the datapath registers are not reset.
module align_rotation_apply #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  ara_pkg::in_beat_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output ara_pkg::out_beat_t result
);

`include "align_rotation_apply_defines.svh"

  // Widths that follow from the number of fraction bits.
  localparam int F    = FRAC_BITS;
  localparam int AW   = F + 2;          // unit vector component
  localparam int NW1  = F + 31;         // |x| * 2^(F+15)
  localparam int QB1  = F + 1;          // unit quotient magnitude bits
  localparam int VSW  = F + 3;          // cross product and dot product
  localparam int OW   = F + 4;          // 1 - c
  localparam int KW   = F + 5;          // entries of K^2
  localparam int NW2  = 2 * F + 8;      // |K^2 * (1 - c)|
  localparam int QB2  = NW2 + 1;        // M quotient magnitude bits
  localparam int VW   = F + 4;          // |v|^2 in Q.F
  localparam int RW   = QB2 + 3;        // rotation matrix entry
  localparam int PW   = 2 * AW;         // product of two unit components
  localparam int SW2  = 2 * VSW;        // product of two v components
  localparam int ACCW = RW + 18;        // row times vector
  localparam int WIDE = ACCW;           // working width of the rounding shifter

  // Pipeline timeline, in register stages, the input register being stage 1.
  localparam int T_SQ = ara_pkg::PRE_STAGES + ara_pkg::SQ_STEPS;  // roots ready
  localparam int T_A  = T_SQ + QB1 + 2;                            // unit vectors
  localparam int T_V  = T_A + 3;                                   // v and c
  localparam int T_P  = T_A + 4;                                   // squares of v
  localparam int T_Q  = T_A + 5;                                   // sums of squares
  localparam int T_R  = T_A + 6;                                   // |v|^2, K^2
  localparam int T_M  = T_A + 7;                                   // K^2 * (1 - c)
  localparam int T_B  = T_M + QB2 + 2;                             // M entries
  localparam int LAT  = T_B + 4;                                   // result register

  localparam logic signed [OW-1:0]   ONE_O  = OW'(64'sd1 <<< F);
  localparam logic signed [RW-1:0]   ONE_R  = RW'(64'sd1 <<< F);
  localparam logic signed [WIDE-1:0] HALF_W = WIDE'(64'sd1 <<< (F - 1));
  localparam logic signed [WIDE-1:0] SAT_HI = WIDE'(32767);
  localparam logic signed [WIDE-1:0] SAT_LO = WIDE'(-32768);

  // Round to nearest, ties away from zero, dropping F fraction bits.
  function automatic logic signed [WIDE-1:0] rshr_f(input logic signed [WIDE-1:0] x);
    logic [WIDE-1:0] m;
    m = x[WIDE-1] ? WIDE'(-x) : WIDE'(x);
    m = (m + WIDE'(HALF_W)) >> F;
    return x[WIDE-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [WIDE-1:0] x);
    logic signed [WIDE-1:0] y;
    y = x;
    if (x > SAT_HI) begin
      y = SAT_HI;
    end else if (x < SAT_LO) begin
      y = SAT_LO;
    end
    return 16'(y);
  endfunction

  // The whole pipeline advances together. It only freezes while a finished
  // result sits in the output register and the consumer stalls it; the freeze
  // holds every stage, bubbles included, so nothing is lost or repeated.
  logic           en;
  logic [LAT:1]   vld;

  assign en           = !(vld[LAT] && result_stall);
  assign item_stall   = !en;
  assign result_valid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], item_valid};
    end
  end

  // ---------------------------------------------------------------------
  // Front end: input register, squared components, squared lengths.
  // The full input beat rides along until the roots are known.
  // ---------------------------------------------------------------------
  ara_pkg::in_beat_t pay_q [1:T_SQ];
  logic signed [15:0] dir1  [2][3];
  logic signed [31:0] sqp   [2][3];
  logic [ara_pkg::SQ_W-1:0] sq2 [2][3];
  logic [ara_pkg::SQ_W-1:0] s3  [2];

  always_comb begin
    dir1[0][0] = pay_q[1].from_x;
    dir1[0][1] = pay_q[1].from_y;
    dir1[0][2] = pay_q[1].from_z;
    dir1[1][0] = pay_q[1].to_x;
    dir1[1][1] = pay_q[1].to_y;
    dir1[1][2] = pay_q[1].to_z;
    for (int d = 0; d < 2; d++) begin
      for (int i = 0; i < 3; i++) begin
        sqp[d][i] = dir1[d][i] * dir1[d][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay_q[1] <= item;
      for (int t = 2; t <= T_SQ; t++) begin
        pay_q[t] <= pay_q[t-1];
      end
      for (int d = 0; d < 2; d++) begin
        for (int i = 0; i < 3; i++) begin
          sq2[d][i] <= $unsigned(sqp[d][i]);
        end
        s3[d] <= sq2[d][0] + sq2[d][1] + sq2[d][2];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Length roots: n = floor(sqrt(s * 2^30)), one root bit per stage for
  // each of the two directions. The radicand is s followed by fifteen
  // zero bit pairs, shifted in from the top two bits at a time.
  // ---------------------------------------------------------------------
  logic [ara_pkg::REM_W-1:0]  sr_rem   [2][1:ara_pkg::SQ_STEPS];
  logic [ara_pkg::ROOT_W-1:0] sr_root  [2][1:ara_pkg::SQ_STEPS];
  logic [ara_pkg::SQ_W-1:0]   sr_rad   [2][1:ara_pkg::SQ_STEPS];
  logic [ara_pkg::REM_W-1:0]  rem_next [2][1:ara_pkg::SQ_STEPS];
  logic [ara_pkg::ROOT_W-1:0] root_next[2][1:ara_pkg::SQ_STEPS];

  always_comb begin
    logic [ara_pkg::REM_W-1:0]  p_rem;
    logic [ara_pkg::ROOT_W-1:0] p_root;
    logic [ara_pkg::SQ_W-1:0]   p_rad;
    logic [ara_pkg::REM_W+1:0]  t;
    logic [ara_pkg::REM_W+1:0]  tr;
    logic                       ge;
    for (int d = 0; d < 2; d++) begin
      for (int k = 1; k <= ara_pkg::SQ_STEPS; k++) begin
        if (k == 1) begin
          p_rem  = '0;
          p_root = '0;
          p_rad  = s3[d];
        end else begin
          p_rem  = sr_rem[d][k-1];
          p_root = sr_root[d][k-1];
          p_rad  = sr_rad[d][k-1];
        end
        t  = {p_rem, p_rad[ara_pkg::SQ_W-1 -: 2]};
        tr = (ara_pkg::REM_W+2)'({p_root, 2'b01});
        ge = (t >= tr);
        rem_next[d][k]  = ge ? ara_pkg::REM_W'(t - tr) : ara_pkg::REM_W'(t);
        root_next[d][k] = {p_root[ara_pkg::ROOT_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int d = 0; d < 2; d++) begin
        for (int k = 1; k <= ara_pkg::SQ_STEPS; k++) begin
          sr_rem[d][k]  <= rem_next[d][k];
          sr_root[d][k] <= root_next[d][k];
          if (k == 1) begin
            sr_rad[d][k] <= {s3[d][ara_pkg::SQ_W-3:0], 2'b00};
          end else begin
            sr_rad[d][k] <= {sr_rad[d][k-1][ara_pkg::SQ_W-3:0], 2'b00};
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Unit vectors: a_i = round(x_i * 2^(F+15) / n). Six dividers run side by
  // side. A zero root means a zero direction, which is remembered as a flag
  // next to the vector to turn; the dividers then produce don't-care values.
  // ---------------------------------------------------------------------
  logic signed [15:0]   dsq    [2][3];
  logic [NW1-1:0]       un_num [2][3];
  logic                 un_neg [2][3];
  logic signed [AW-1:0] a_u    [2][3];

  always_comb begin
    logic [15:0] mag;
    dsq[0][0] = pay_q[T_SQ].from_x;
    dsq[0][1] = pay_q[T_SQ].from_y;
    dsq[0][2] = pay_q[T_SQ].from_z;
    dsq[1][0] = pay_q[T_SQ].to_x;
    dsq[1][1] = pay_q[T_SQ].to_y;
    dsq[1][2] = pay_q[T_SQ].to_z;
    for (int d = 0; d < 2; d++) begin
      for (int i = 0; i < 3; i++) begin
        mag          = dsq[d][i][15] ? 16'(-dsq[d][i]) : 16'(dsq[d][i]);
        un_num[d][i] = NW1'(mag) << (F + 15);
        un_neg[d][i] = dsq[d][i][15];
      end
    end
  end

  for (genvar gd = 0; gd < 2; gd++) begin : g_dir
    for (genvar gi = 0; gi < 3; gi++) begin : g_cmp
      ara_div_pipe #(
        .NUM_W (NW1),
        .DEN_W (ara_pkg::ROOT_W),
        .QUO_W (QB1)
      ) u_unit_div (
        .clk (clk),
        .en  (en),
        .num (un_num[gd][gi]),
        .den (sr_root[gd][ara_pkg::SQ_STEPS]),
        .neg (un_neg[gd][gi]),
        .quo (a_u[gd][gi])
      );
    end
  end

  // Vector to turn and the zero-direction flag, carried to the output.
  ara_pkg::vec3_t       wv_dl [T_SQ+1:LAT-1];
  logic [LAT-1:T_SQ+1]  zf_dl;

  always_ff @(posedge clk) begin
    if (en) begin
      wv_dl[T_SQ+1] <= '{x: pay_q[T_SQ].vec_x, y: pay_q[T_SQ].vec_y, z: pay_q[T_SQ].vec_z};
      zf_dl[T_SQ+1] <= (sr_root[0][ara_pkg::SQ_STEPS] == '0) ||
                       (sr_root[1][ara_pkg::SQ_STEPS] == '0);
      for (int t = T_SQ + 2; t <= LAT - 1; t++) begin
        wv_dl[t] <= wv_dl[t-1];
        zf_dl[t] <= zf_dl[t-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Cross product v and dot product c of the unit vectors, then the
  // squares that build |v|^2 and K^2, and the scale factor 1 - c.
  // ---------------------------------------------------------------------
  logic signed [PW-1:0]   cp [6];
  logic signed [PW-1:0]   dp [3];
  logic signed [PW:0]     cd [3];
  logic signed [PW+1:0]   ds;
  logic signed [VSW-1:0]  v_dl [T_V:T_B][3];
  logic signed [VSW-1:0]  c_v;
  logic signed [SW2-1:0]  sqv  [3];
  logic signed [SW2-1:0]  poff [3];
  logic signed [OW-1:0]   om_p, om_q, om_r;
  logic signed [SW2+1:0]  vvx;
  logic signed [SW2+1:0]  psum [3];
  logic signed [KW-1:0]   offr_q [3];
  logic signed [KW-1:0]   offr_r [3];
  logic signed [KW-1:0]   diag_r [3];
  logic [VW-1:0]          vv_r, vv_m;
  logic signed [KW+OW-1:0] prod_m [6];
  logic [LAT-1:T_M]       dg_dl;

  always_ff @(posedge clk) begin
    if (en) begin
      // products of unit components
      cp[0] <= a_u[0][1] * a_u[1][2];
      cp[1] <= a_u[0][2] * a_u[1][1];
      cp[2] <= a_u[0][2] * a_u[1][0];
      cp[3] <= a_u[0][0] * a_u[1][2];
      cp[4] <= a_u[0][0] * a_u[1][1];
      cp[5] <= a_u[0][1] * a_u[1][0];
      for (int i = 0; i < 3; i++) begin
        dp[i] <= a_u[0][i] * a_u[1][i];
      end
      // differences and sum
      for (int i = 0; i < 3; i++) begin
        cd[i] <= (PW+1)'(cp[2*i]) - (PW+1)'(cp[2*i+1]);
      end
      ds <= (PW+2)'(dp[0]) + (PW+2)'(dp[1]) + (PW+2)'(dp[2]);
      // back to Q.F
      for (int i = 0; i < 3; i++) begin
        v_dl[T_V][i] <= VSW'(rshr_f(WIDE'(cd[i])));
      end
      c_v <= VSW'(rshr_f(WIDE'(ds)));
      for (int t = T_V + 1; t <= T_B; t++) begin
        v_dl[t] <= v_dl[t-1];
      end
      // squares and cross terms of v
      for (int i = 0; i < 3; i++) begin
        sqv[i] <= v_dl[T_V][i] * v_dl[T_V][i];
      end
      poff[0] <= v_dl[T_V][0] * v_dl[T_V][1];
      poff[1] <= v_dl[T_V][0] * v_dl[T_V][2];
      poff[2] <= v_dl[T_V][1] * v_dl[T_V][2];
      om_p    <= ONE_O - OW'(c_v);
      // sums of squares; the diagonal of K^2 needs the other two squares
      vvx     <= (SW2+2)'(sqv[0]) + (SW2+2)'(sqv[1]) + (SW2+2)'(sqv[2]);
      psum[0] <= (SW2+2)'(sqv[1]) + (SW2+2)'(sqv[2]);
      psum[1] <= (SW2+2)'(sqv[0]) + (SW2+2)'(sqv[2]);
      psum[2] <= (SW2+2)'(sqv[0]) + (SW2+2)'(sqv[1]);
      for (int i = 0; i < 3; i++) begin
        offr_q[i] <= KW'(rshr_f(WIDE'(poff[i])));
      end
      om_q <= om_p;
      // |v|^2 and the diagonal of K^2 in Q.F
      vv_r <= VW'((WIDE'(vvx) + HALF_W) >>> F);
      for (int i = 0; i < 3; i++) begin
        diag_r[i] <= KW'(-rshr_f(WIDE'(psum[i])));
      end
      offr_r <= offr_q;
      om_r   <= om_q;
      // numerators of M
      for (int i = 0; i < 3; i++) begin
        prod_m[i]     <= diag_r[i] * om_r;
        prod_m[i + 3] <= offr_r[i] * om_r;
      end
      vv_m      <= vv_r;
      dg_dl[T_M] <= (vv_r == '0);
      for (int t = T_M + 1; t <= LAT - 1; t++) begin
        dg_dl[t] <= dg_dl[t-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // M = K^2 * (1 - c) / |v|^2. K^2 is symmetric, so six dividers cover all
  // nine entries. A zero |v|^2 marks the parallel or antiparallel case; the quotients are
  // then don't-care and the output takes the vector unchanged.
  // ---------------------------------------------------------------------
  logic [NW2-1:0]          m_num [6];
  logic                    m_neg [6];
  logic signed [QB2:0]     mq    [6];

  always_comb begin
    for (int n = 0; n < 6; n++) begin
      m_neg[n] = prod_m[n][KW+OW-1];
      m_num[n] = m_neg[n] ? NW2'(-prod_m[n]) : NW2'(prod_m[n]);
    end
  end

  for (genvar gn = 0; gn < 6; gn++) begin : g_m
    ara_div_pipe #(
      .NUM_W (NW2),
      .DEN_W (VW),
      .QUO_W (QB2)
    ) u_m_div (
      .clk (clk),
      .en  (en),
      .num (m_num[gn]),
      .den (vv_m),
      .neg (m_neg[gn]),
      .quo (mq[gn])
    );
  end

  // ---------------------------------------------------------------------
  // R = I + K + M, then R times the vector, rounding and saturation.
  // ---------------------------------------------------------------------
  logic signed [VSW-1:0]   kx  [3][3];
  logic signed [RW-1:0]    rm  [3][3];
  logic signed [RW+15:0]   rp  [3][3];
  logic signed [ACCW-1:0]  acc [3];
  logic signed [15:0]      wq  [3];
  logic signed [15:0]      outc [3];
  logic                    deg;
  ara_pkg::out_beat_t      result_q;

  always_comb begin
    kx[0][0] = '0;
    kx[0][1] = -v_dl[T_B][2];
    kx[0][2] = v_dl[T_B][1];
    kx[1][0] = v_dl[T_B][2];
    kx[1][1] = '0;
    kx[1][2] = -v_dl[T_B][0];
    kx[2][0] = -v_dl[T_B][1];
    kx[2][1] = v_dl[T_B][0];
    kx[2][2] = '0;
    wq[0] = wv_dl[T_B+1].x;
    wq[1] = wv_dl[T_B+1].y;
    wq[2] = wv_dl[T_B+1].z;
    for (int i = 0; i < 3; i++) begin
      outc[i] = sat16(rshr_f(WIDE'(acc[i])));
    end
    deg = zf_dl[LAT-1] || dg_dl[LAT-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rm[i][j] <= RW'(kx[i][j]) + RW'(mq[ara_pkg::K2_SEL[i][j]]) +
                      ((i == j) ? ONE_R : '0);
        end
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rp[i][j] <= rm[i][j] * wq[j];
        end
      end
      for (int i = 0; i < 3; i++) begin
        acc[i] <= ACCW'(rp[i][0]) + ACCW'(rp[i][1]) + ACCW'(rp[i][2]);
      end
      // Degenerate beats pass the vector through untouched.
      result_q.out_x      <= deg ? wv_dl[LAT-1].x : outc[0];
      result_q.out_y      <= deg ? wv_dl[LAT-1].y : outc[1];
      result_q.out_z      <= deg ? wv_dl[LAT-1].z : outc[2];
      result_q.degenerate <= deg;
    end
  end

  assign result = result_q;

  // A frozen pipeline keeps every valid bit where it is.
  `ARA_ASSERT_NXT(a_frozen_valids, !en && !rst, $stable(vld))
  // An advancing pipeline moves the last valid bit into the output register.
  `ARA_ASSERT_NXT(a_last_stage_moves, en && !rst, vld[LAT] == $past(vld[LAT-1]))
  // A zero direction always reports degenerate.
  `ARA_ASSERT_NXT(a_zero_dir_flag, en && !rst && vld[LAT-1] && zf_dl[LAT-1], result.degenerate)
  // A degenerate beat carries the original x component.
  `ARA_ASSERT_NXT(a_pass_x, en && !rst && vld[LAT-1] && deg,
                  result.out_x == $past(wv_dl[LAT-1].x))

endmodule

@@ tb/align_rotation_apply_tb.sv @@
`timescale 1ns / 1ps

module align_rotation_apply_tb;

  localparam int FRAC       = 14;
  localparam int LATENCY    = 3 * FRAC + 59;
  localparam int CYCLE_CAP  = 400000;
  localparam int RAND_BEATS = 615;

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_stall;
  ara_pkg::in_beat_t  item;
  logic               result_valid;
  logic               result_stall = 1'b0;
  ara_pkg::out_beat_t result;

  align_rotation_apply #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  // Rotated vectors still owed by the block, oldest first.
  ara_pkg::out_beat_t rotation_expected[$];
  int        mismatches = 0;
  int        cycles = 0;
  int        send_idle_pct;
  int        stall_pct;

  always #2 clk = ~clk;

  // Rounding right shift, ties away from zero.
  function automatic longint round_shift(longint x, int s);
    longint unsigned m;
    m = (x < 0) ? longint'(-x) : x;
    m = (m + (64'd1 << (s - 1))) >> s;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  // Rounding division, ties away from zero.
  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned m;
    m = (num < 0) ? longint'(-num) : num;
    m = (m + den / 2) / den;
    return (num < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // Scales a direction to unit length in Q.F; returns 0 for the zero vector.
  function automatic bit to_unit(input longint p[3], output longint u[3]);
    longint unsigned s, n;
    s = 0;
    for (int i = 0; i < 3; i++) s += longint'(p[i] * p[i]);
    if (s == 0) return 0;
    n = int_sqrt(s << 30);
    for (int i = 0; i < 3; i++) u[i] = round_div(p[i] * (64'sd1 << (FRAC + 15)), n);
    return 1;
  endfunction

  function automatic logic signed [15:0] clamp16(longint x);
    if (x > 32767) return 16'sh7fff;
    if (x < -32768) return 16'sh8000;
    return x[15:0];
  endfunction

  function automatic ara_pkg::out_beat_t predict_rotation(ara_pkg::in_beat_t b);
    longint f[3], t[3], w[3], a[3], u[3], v[3], r[3][3];
    longint c, k2, acc, one, skew;
    longint unsigned sq[3], vvx, vv;
    ara_pkg::out_beat_t o;
    one = 64'sd1 << FRAC;
    f = '{b.from_x, b.from_y, b.from_z};
    t = '{b.to_x, b.to_y, b.to_z};
    w = '{b.vec_x, b.vec_y, b.vec_z};
    vv = 0;
    vvx = 0;
    c = 0;
    if (to_unit(f, a) && to_unit(t, u)) begin
      v[0] = round_shift(a[1] * u[2] - a[2] * u[1], FRAC);
      v[1] = round_shift(a[2] * u[0] - a[0] * u[2], FRAC);
      v[2] = round_shift(a[0] * u[1] - a[1] * u[0], FRAC);
      c = round_shift(a[0] * u[0] + a[1] * u[1] + a[2] * u[2], FRAC);
      for (int i = 0; i < 3; i++) sq[i] = v[i] * v[i];
      vvx = sq[0] + sq[1] + sq[2];
      vv = (vvx + (64'd1 << (FRAC - 1))) >> FRAC;
    end
    if (vv == 0) begin
      o.out_x = b.vec_x;
      o.out_y = b.vec_y;
      o.out_z = b.vec_z;
      o.degenerate = 1'b1;
      return o;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        // Skew matrix of v: K[i][j] = -eps(i,j,k) v[k].
        if (i == j) skew = 0;
        else if ((j - i + 3) % 3 == 1) skew = -v[3 - i - j];
        else skew = v[3 - i - j];
        if (i == j) k2 = -round_shift(longint'(vvx - sq[i]), FRAC);
        else k2 = round_shift(v[i] * v[j], FRAC);
        r[i][j] = skew + round_div(k2 * (one - c), vv) + ((i == j) ? one : 0);
      end
    end
    acc = r[0][0] * w[0] + r[0][1] * w[1] + r[0][2] * w[2];
    o.out_x = clamp16(round_shift(acc, FRAC));
    acc = r[1][0] * w[0] + r[1][1] * w[1] + r[1][2] * w[2];
    o.out_y = clamp16(round_shift(acc, FRAC));
    acc = r[2][0] * w[0] + r[2][1] * w[1] + r[2][2] * w[2];
    o.out_z = clamp16(round_shift(acc, FRAC));
    o.degenerate = 1'b0;
    return o;
  endfunction

  // Drives one beat from a falling edge and returns at the falling edge after it
  // was accepted. Valid stays high across back-to-back beats.
  task automatic send_item(ara_pkg::in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item <= b;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    rotation_expected.insert(rotation_expected.size(), predict_rotation(b));
    @(negedge clk);
  endtask

  function automatic ara_pkg::in_beat_t make_beat(logic signed [15:0] fx, fy, fz,
                                                  tx, ty, tz, vx, vy, vz);
    ara_pkg::in_beat_t b;
    b = '{fx, fy, fz, tx, ty, tz, vx, vy, vz};
    return b;
  endfunction

  function automatic logic signed [15:0] rand16();
    return 16'($urandom);
  endfunction

  // Negation that stays inside 16 bits.
  function automatic logic signed [15:0] neg16(logic signed [15:0] x);
    return (x == -16'sd32768) ? 16'sh7fff : -x;
  endfunction

  // Receiver stall, re-drawn every cycle.
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Result checker: every accepted beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (rotation_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", result);
      end else begin
        ara_pkg::out_beat_t want;
        want = rotation_expected.pop_front();
        if (result.out_x !== want.out_x || result.out_y !== want.out_y ||
            result.out_z !== want.out_z || result.degenerate !== want.degenerate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%0d y=%0d z=%0d deg=%0b, got x=%0d y=%0d z=%0d deg=%0b",
                     want.out_x, want.out_y, want.out_z, want.degenerate,
                     result.out_x, result.out_y, result.out_z, result.degenerate);
        end
      end
    end
  end

  // Overall watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Extremes, zero directions, parallel and antiparallel pairs, saturation.
  task automatic test_directed();
    send_item(make_beat(0, 0, 0, 16384, 0, 0, 100, -200, 300));
    send_item(make_beat(16384, 0, 0, 0, 0, 0, -32768, 32767, 0));
    send_item(make_beat(0, 0, 0, 0, 0, 0, 32767, -32768, 1));
    send_item(make_beat(16384, 0, 0, 16384, 0, 0, 5, 6, 7));
    send_item(make_beat(1000, 2000, -3000, 2000, 4000, -6000, 1, 2, 3));
    send_item(make_beat(16384, 0, 0, -16384, 0, 0, 1234, -4321, 999));
    send_item(make_beat(-32768, -32768, -32768, 32767, 32767, 32767, 500, 600, 700));
    send_item(make_beat(16384, 0, 0, 0, 16384, 0, 16384, 0, 0));
    send_item(make_beat(0, 16384, 0, 0, 0, 16384, 0, 16384, 0));
    send_item(make_beat(0, 0, 16384, 16384, 0, 0, 0, 0, 16384));
    send_item(make_beat(32767, 32767, 32767, -32768, -32768, -32768,
                        -32768, -32768, -32768));
    send_item(make_beat(-32768, 0, 0, 0, 32767, 0, 32767, 32767, 32767));
    send_item(make_beat(16384, 0, 0, -16384, 40, 0, 32767, 32767, 32767));
    send_item(make_beat(16384, 0, 0, -16384, -30, 25, -32768, 32767, -32768));
    send_item(make_beat(1, 0, 0, 0, 1, 0, 32767, -32768, 32767));
    send_item(make_beat(16384, 0, 0, 16384, 1, 0, 1000, 1000, 1000));
    send_item(make_beat(-1, -1, -1, 1, 1, 1, 77, 88, 99));
    send_item(make_beat(11585, 11585, 0, 0, 11585, 11585, -32768, 0, 32767));
    send_item(make_beat(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 0));
    send_item(make_beat(32767, -32768, 32767, -32768, 32767, -32768, 1, -1, 1));
  endtask

  // Random beats: half general directions, the rest near-parallel and near-antiparallel
  // pairs, small magnitudes, zero directions and parallel pairs of unequal length.
  task automatic test_random(int beats);
    ara_pkg::in_beat_t b;
    int kind;
    for (int n = 0; n < beats; n++) begin
      b = make_beat(rand16(), rand16(), rand16(), rand16(), rand16(), rand16(),
                    rand16(), rand16(), rand16());
      kind = $urandom_range(9);
      case (kind)
        0: begin
          b.to_x = b.from_x + 16'($signed($urandom_range(8)) - 4);
          b.to_y = b.from_y + 16'($signed($urandom_range(8)) - 4);
          b.to_z = b.from_z + 16'($signed($urandom_range(8)) - 4);
        end
        1: begin
          b.to_x = neg16(b.from_x) + 16'($signed($urandom_range(60)) - 30);
          b.to_y = neg16(b.from_y);
          b.to_z = neg16(b.from_z);
        end
        2: begin
          b.from_x = 16'($signed($urandom_range(8)) - 4);
          b.from_y = 16'($signed($urandom_range(8)) - 4);
          b.from_z = 16'($signed($urandom_range(8)) - 4);
        end
        3: begin
          if ($urandom_range(1)) b.from_x = 0; else b.to_x = 0;
          if ($urandom_range(1)) begin
            b.from_y = 0;
            b.from_z = 0;
            b.from_x = 0;
          end else begin
            b.to_y = 0;
            b.to_z = 0;
            b.to_x = 0;
          end
        end
        4: begin
          b.to_x = b.from_x >>> 1;
          b.to_y = b.from_y >>> 1;
          b.to_z = b.from_z >>> 1;
        end
        default: ;
      endcase
      send_item(b);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    send_idle_pct = 7;
    stall_pct = 61;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random(RAND_BEATS);
    send_idle_pct = 61;
    stall_pct = 7;
    test_random(RAND_BEATS);
    send_idle_pct = 0;
    stall_pct = 0;
    test_random(RAND_BEATS);
    item_valid <= 1'b0;

    while (rotation_expected.size() != 0) @(negedge clk);
    repeat (LATENCY + 20) @(negedge clk);
    if (mismatches == 0 && rotation_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
